>>> hw/rtl/pm_pkg.sv
// types and constants for the polynomial multiplier
// no dependencies; imported by polynomial_multiply_top and its testbench

package pm_pkg;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CALC,
        S_DRAIN,
        S_ERD,
        S_ESEND
    } pm_state_t;

    // 32x32 slice of one coefficient product
    typedef enum logic [1:0] {
        CH_LL,
        CH_LH,
        CH_HL
    } pm_chunk_t;

    localparam int unsigned SLICE_W = 32;
    localparam int unsigned OUT_W   = 32;

    function automatic pm_chunk_t pm_chunk_succ(input pm_chunk_t c);
        pm_chunk_t r;
        unique case (c)
            CH_LL:   r = CH_LH;
            CH_LH:   r = CH_HL;
            default: r = CH_LL;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/polynomial_multiply_top.sv
// schoolbook polynomial multiplier, operand stores, shared multiplier and emitter
// depends on pm_pkg

// Items load one coefficient per cycle while in_stall is low (first operand with
// mode 0, then the second with mode 1); the mode 1 item with last_in closes the
// pair and starts the product, during which in_stall stays high. The product runs
// one shared 32x32 multiplier fed from the two operand memories, with one slice
// product per coefficient pair for COEFF_WIDTH up to 32 and three above. Results
// then leave one at a time, each read from the product memory and held until taken;
// a zero product gives a single result with zero_poly set. Coefficients past
// MAX_TERMS per operand are dropped and reported on overflow.

module polynomial_multiply_top
    import pm_pkg::*;
#(
    parameter int unsigned MAX_TERMS   = 32,
    parameter int unsigned COEFF_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] coeff_in,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] coeff_out,
    output logic               last_out,
    output logic               zero_poly,
    output logic               overflow
);

    localparam int unsigned IW    = $clog2(MAX_TERMS);
    localparam int unsigned CNTW  = $clog2(MAX_TERMS + 1);
    localparam int unsigned PLEN  = 2 * MAX_TERMS - 1;
    localparam int unsigned KW    = $clog2(PLEN);
    localparam int unsigned TW    = $clog2(PLEN + 1);
    localparam pm_chunk_t   CH_END = (COEFF_WIDTH > SLICE_W) ? CH_HL : CH_LL;

    logic [COEFF_WIDTH-1:0] fa_mem [MAX_TERMS];
    logic [COEFF_WIDTH-1:0] fb_mem [MAX_TERMS];
    logic [COEFF_WIDTH-1:0] pr_mem [PLEN];

    pm_state_t         state_reg, state_next;
    logic [CNTW-1:0]   na_reg, na_next;
    logic [CNTW-1:0]   nb_reg, nb_next;
    logic              drop_reg, drop_next;
    logic [KW-1:0]     kmax_reg, kmax_next;
    logic [TW-1:0]     top_reg;
    logic [KW-1:0]     e_reg, e_next;

    // operand fetch sequencer
    logic [KW-1:0]     gk_reg, gk_next;
    logic [IW-1:0]     gi_reg, gi_next;
    pm_chunk_t         gch_reg, gch_next;
    logic [IW-1:0]     gj;
    logic              issue;
    logic              g_first, g_last, g_ihi;
    logic [KW:0]       k1_ext;
    logic [IW-1:0]     lo_next;

    // pipeline stage tags
    logic              v1_reg, v2_reg;
    logic              f1_reg, f2_reg;
    logic              l1_reg, l2_reg;
    logic [KW-1:0]     k1_reg, k2_reg;
    pm_chunk_t         ch1_reg, ch2_reg;

    logic [COEFF_WIDTH-1:0] ard_reg, brd_reg;
    logic [COEFF_WIDTH-1:0] prd_reg;
    logic [63:0]            a64, b64;
    logic [SLICE_W-1:0]     ma, mb;
    logic [63:0]            pp_reg;
    logic [63:0]            term64;
    logic [COEFF_WIDTH-1:0] acc_reg, acc_next;

    logic                   in_acc;
    logic                   out_acc;
    logic [COEFF_WIDTH-1:0] cin;
    logic [CNTW:0]          len_sum;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign cin     = COEFF_WIDTH'(coeff_in);

    // load path: operand stores
    always_ff @(posedge clk)
    begin
        if (in_acc && !mode && na_reg < CNTW'(MAX_TERMS))
        begin
            fa_mem[na_reg[IW-1:0]] <= cin;
        end
        if (in_acc && mode && nb_reg < CNTW'(MAX_TERMS))
        begin
            fb_mem[nb_reg[IW-1:0]] <= cin;
        end
        ard_reg <= fa_mem[gi_reg];
        brd_reg <= fb_mem[gj];
    end

    // fetch sequencer: index range of the first operand for product term gk
    assign gj      = IW'(gk_reg - KW'(gi_reg));
    assign g_ihi   = (gi_reg == IW'(na_reg - CNTW'(1))) || ((KW + 1)'(gi_reg) == (KW + 1)'(gk_reg));
    assign k1_ext  = (KW + 1)'(gk_reg) + (KW + 1)'(2);
    // lower bound of i for term gk+1 is (gk+2) - nb when positive
    assign lo_next = (k1_ext > (KW + 1)'(nb_reg)) ? IW'(k1_ext - (KW + 1)'(nb_reg)) : '0;
    assign g_last  = g_ihi && (gch_reg == CH_END);
    assign issue   = (state_reg == S_CALC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_first <= 1'b1;
        end
        else if (issue)
        begin
            g_first <= g_last;
        end
        else
        begin
            g_first <= 1'b1;
        end
    end

    always_comb
    begin
        gk_next  = gk_reg;
        gi_next  = gi_reg;
        gch_next = gch_reg;
        if (!issue)
        begin
            gk_next  = '0;
            gi_next  = '0;
            gch_next = CH_LL;
        end
        else if (gch_reg != CH_END)
        begin
            gch_next = pm_chunk_succ(gch_reg);
        end
        else
        begin
            gch_next = CH_LL;
            if (g_ihi)
            begin
                gk_next = gk_reg + KW'(1);
                gi_next = lo_next;
            end
            else
            begin
                gi_next = gi_reg + IW'(1);
            end
        end
    end

    // multiply slice select
    assign a64 = 64'(ard_reg);
    assign b64 = 64'(brd_reg);

    always_comb
    begin
        case (ch1_reg)
            CH_LH:
            begin
                ma = a64[31:0];
                mb = b64[63:32];
            end
            CH_HL:
            begin
                ma = a64[63:32];
                mb = b64[31:0];
            end
            default:
            begin
                ma = a64[31:0];
                mb = b64[31:0];
            end
        endcase
    end

    assign term64   = (ch2_reg == CH_LL) ? pp_reg : {pp_reg[31:0], 32'd0};
    assign acc_next = (f2_reg ? '0 : acc_reg) + term64[COEFF_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        gk_reg  <= gk_next;
        gi_reg  <= gi_next;
        gch_reg <= gch_next;
        f1_reg  <= g_first;
        l1_reg  <= g_last;
        k1_reg  <= gk_reg;
        ch1_reg <= gch_reg;
        pp_reg  <= 64'(ma) * 64'(mb);
        f2_reg  <= f1_reg;
        l2_reg  <= l1_reg;
        k2_reg  <= k1_reg;
        ch2_reg <= ch1_reg;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (v2_reg && l2_reg)
        begin
            pr_mem[k2_reg] <= acc_next;
        end
        if (state_reg == S_ERD)
        begin
            prd_reg <= pr_mem[e_reg];
        end
    end

    // control: operand lengths once the closing item is counted
    assign len_sum = (CNTW + 1)'(na_reg) + (CNTW + 1)'(nb_reg)
                   + ((nb_reg < CNTW'(MAX_TERMS)) ? (CNTW + 1)'(1) : (CNTW + 1)'(0));

    always_comb
    begin
        state_next = state_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        drop_next  = drop_reg;
        kmax_next  = kmax_reg;
        e_next     = e_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                e_next = '0;
                if (in_acc)
                begin
                    if (!mode)
                    begin
                        if (na_reg < CNTW'(MAX_TERMS))
                            na_next = na_reg + CNTW'(1);
                        else
                            drop_next = 1'b1;
                    end
                    else
                    begin
                        if (nb_reg < CNTW'(MAX_TERMS))
                            nb_next = nb_reg + CNTW'(1);
                        else
                            drop_next = 1'b1;
                        if (last_in)
                        begin
                            kmax_next  = KW'(len_sum - (CNTW + 1)'(2));
                            state_next = (na_reg == '0) ? S_ERD : S_CALC;
                        end
                    end
                end
            end
            S_CALC:
            begin
                if (g_last && gk_reg == kmax_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_ERD;
            end
            S_ERD:
            begin
                state_next = S_ESEND;
            end
            S_ESEND:
            begin
                if (out_acc)
                begin
                    if (last_out)
                    begin
                        state_next = S_LOAD;
                        na_next    = '0;
                        nb_next    = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        e_next     = e_reg + KW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            na_reg    <= '0;
            nb_reg    <= '0;
            drop_reg  <= 1'b0;
            kmax_reg  <= '0;
            e_reg     <= '0;
            top_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            drop_reg  <= drop_next;
            kmax_reg  <= kmax_next;
            e_reg     <= e_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (state_reg == S_LOAD)
            begin
                top_reg <= '0;
            end
            else if (v2_reg && l2_reg && acc_next != '0)
            begin
                // highest nonzero term seen so far, terms finish in ascending order
                top_reg <= TW'(k2_reg) + TW'(1);
            end
        end
    end

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = (state_reg == S_ESEND);
    assign zero_poly = (top_reg == '0);
    assign last_out  = zero_poly || (TW'(e_reg) + TW'(1) == top_reg);
    assign coeff_out = zero_poly ? '0 : OUT_W'(prd_reg);
    assign overflow  = drop_reg;

endmodule

>>> hw/rtl/pm_checker.sv
// port-level checks for the polynomial multiplier
// no package use; bound to polynomial_multiply_top below

module pm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] coeff_out,
    input logic        last_out,
    input logic        zero_poly
);

    // no new item is taken while a product is being delivered
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken during result delivery");

    // a zero product is a single zero item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_poly |-> last_out && coeff_out == 32'd0)
        else $error("bad zero polynomial item");

    // mid-product the block stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_out |=> in_stall)
        else $error("block freed before last item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coeff_out) && $stable(last_out))
        else $error("stalled item changed");

endmodule

bind polynomial_multiply_top pm_checker u_pm_checker (.*);

>>> tb/sv/polynomial_multiply_top_tb.sv
`timescale 1ns / 100ps
// testbench for polynomial_multiply_top: streams operand pairs with random gaps and
// stalls, predicts each product's coefficients in a scoreboard class and checks them
// depends on pm_pkg and polynomial_multiply_top

module polynomial_multiply_top_tb;
    import pm_pkg::*;

    localparam int unsigned TERMS        = 32;
    localparam int unsigned CW           = OUT_W;
    localparam int          RANDOM_ITEMS = 270;
    localparam int          SETTLE       = 16;

    typedef struct packed {
        logic [CW-1:0] coeff;
        logic          last;
        logic          zero;
        logic          ovf;
    } product_term_t;

    class product_scoreboard;
        logic [CW-1:0] first_terms [TERMS];
        logic [CW-1:0] second_terms [TERMS];
        int unsigned   first_len;
        int unsigned   second_len;
        logic          dropped;
        product_term_t expected_terms [$];
        int            mismatches;
        int            results_checked;
        int            products;
        int            zero_products;
        int            dropped_products;

        function new();
            first_len        = 0;
            second_len       = 0;
            dropped          = 1'b0;
            mismatches       = 0;
            results_checked  = 0;
            products         = 0;
            zero_products    = 0;
            dropped_products = 0;
        endfunction

        // accepted item: store it, and on the closing item work out the product
        function void note_coeff(logic m, logic [CW-1:0] c, logic l);
            logic [CW-1:0] prod [2*TERMS-1];
            int unsigned   len;
            int unsigned   top;
            if (m == 1'b0) begin
                if (first_len < TERMS) begin
                    first_terms[first_len] = c;
                    first_len++;
                end
                else
                    dropped = 1'b1;
                return;
            end
            if (second_len < TERMS) begin
                second_terms[second_len] = c;
                second_len++;
            end
            else
                dropped = 1'b1;
            if (!l)
                return;

            len = 0;
            if (first_len > 0 && second_len > 0) begin
                len = first_len + second_len - 1;
                for (int k = 0; k < len; k++)
                    prod[k] = '0;
                for (int i = 0; i < first_len; i++)
                    for (int j = 0; j < second_len; j++)
                        prod[i+j] = prod[i+j] + first_terms[i] * second_terms[j];
            end
            top = len;
            while (top > 0 && prod[top-1] == '0)
                top--;

            products++;
            if (dropped)
                dropped_products++;
            if (top == 0) begin
                zero_products++;
                expected_terms.push_back(product_term_t'{'0, 1'b1, 1'b1, dropped});
            end
            else begin
                for (int k = 0; k < top; k++)
                    expected_terms.push_back(
                        product_term_t'{prod[k], (k + 1 == top), 1'b0, dropped});
            end
            first_len  = 0;
            second_len = 0;
            dropped    = 1'b0;
        endfunction

        function void check_result(logic [CW-1:0] c, logic lo, logic z, logic ov);
            product_term_t want;
            results_checked++;
            if (expected_terms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: coeff %h last %b zero %b ovf %b",
                             c, lo, z, ov);
                return;
            end
            want = expected_terms.pop_front();
            if (c !== want.coeff || lo !== want.last || z !== want.zero
                || ov !== want.ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected coeff %h last %b zero %b ovf %b, %s %h %b %b %b",
                             results_checked, want.coeff, want.last, want.zero, want.ovf,
                             "got", c, lo, z, ov);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic          mode;
    logic [CW-1:0] coeff_in;
    logic          last_in;
    logic          out_valid;
    logic          out_stall;
    logic [CW-1:0] coeff_out;
    logic          last_out;
    logic          zero_poly;
    logic          overflow;

    product_scoreboard sb;
    int                items_sent;
    bit                gaps_on;

    polynomial_multiply_top #(
        .MAX_TERMS   (TERMS),
        .COEFF_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .coeff_in  (coeff_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .coeff_out (coeff_out),
        .last_out  (last_out),
        .zero_poly (zero_poly),
        .overflow  (overflow)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CW-1:0] pick_coeff();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 35)
            return $urandom_range(0, 4) - 2;
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    // operand length; zero leaves the first operand empty
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 72)
            return $urandom_range(1, 4);
        if (r < 94)
            return $urandom_range(5, 12);
        return $urandom_range(13, 32);
    endfunction

    task automatic send_coeff(input logic m, input logic [CW-1:0] c, input logic l);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        coeff_in <= c;
        last_in  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_coeff(m, c, l);
        items_sent++;
    endtask

    // one operand pair with random content, first-operand markers and stray items
    task automatic send_product(input int na, input int nb);
        int r;
        int marker_at;
        int noise_at;
        bit zero_fill;
        r = $urandom_range(0, 99);
        if (r < 70)
            marker_at = na - 1;
        else if (r < 82 && na > 0)
            marker_at = $urandom_range(0, na - 1);
        else
            marker_at = -1;
        noise_at  = ($urandom_range(0, 9) == 0 && nb > 1) ? $urandom_range(0, nb - 2) : -1;
        zero_fill = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < na; i++)
            send_coeff(1'b0, zero_fill ? '0 : pick_coeff(), i == marker_at);
        for (int j = 0; j < nb; j++)
        begin
            send_coeff(1'b1, pick_coeff(), j == nb - 1);
            // a first-operand item slipped in between second-operand items
            if (j == noise_at)
                send_coeff(1'b0, pick_coeff(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_terms.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off while items keep coming
    initial
    begin
        int   r;
        int   hold;
        logic stall_next;
        bit   long_done;
        out_stall  = 1'b0;
        stall_next = 1'b0;
        hold       = 0;
        long_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(coeff_out, last_out, zero_poly, overflow);
            if (hold > 0)
                hold--;
            else if (!long_done && sb.products >= 12)
            begin
                long_done  = 1'b1;
                stall_next = 1'b1;
                hold       = 600;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    stall_next = 1'b0;
                    hold       = $urandom_range(0, 19);
                end
                else if (r < 85)
                begin
                    stall_next = 1'b1;
                    hold       = $urandom_range(0, 2);
                end
                else if (r < 97)
                begin
                    stall_next = 1'b1;
                    hold       = $urandom_range(3, 11);
                end
                else
                begin
                    stall_next = 1'b1;
                    hold       = $urandom_range(19, 39);
                end
            end
            out_stall <= stall_next;
        end
    end

    initial
    begin
        int random_start;
        int seq;
        int na;
        int nb;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = 1'b0;
        coeff_in   = '0;
        last_in    = 1'b0;
        items_sent = 0;
        gaps_on    = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // smallest product
        send_coeff(1'b0, 32'h0000_0001, 1'b1);
        send_coeff(1'b1, 32'h0000_0001, 1'b1);
        // extreme coefficients, products wrap
        send_coeff(1'b0, 32'h8000_0000, 1'b0);
        send_coeff(1'b0, 32'h7fff_ffff, 1'b1);
        send_coeff(1'b1, 32'hffff_ffff, 1'b0);
        send_coeff(1'b1, 32'h8000_0000, 1'b1);
        // first-operand marker in the middle, more first-operand items after it
        send_coeff(1'b0, 32'h0000_0003, 1'b1);
        send_coeff(1'b0, 32'hffff_fffe, 1'b0);
        send_coeff(1'b0, 32'h0000_0007, 1'b1);
        send_coeff(1'b1, 32'h0000_0002, 1'b1);
        // empty first operand
        send_coeff(1'b1, 32'h0000_0005, 1'b0);
        send_coeff(1'b1, 32'h0000_0006, 1'b1);
        // all-zero operand gives the zero polynomial
        send_coeff(1'b0, 32'h0000_0000, 1'b0);
        send_coeff(1'b0, 32'h0000_0000, 1'b1);
        send_coeff(1'b1, 32'h0000_0009, 1'b1);
        // top coefficient wraps to zero and is trimmed
        send_coeff(1'b0, 32'h0000_0001, 1'b0);
        send_coeff(1'b0, 32'h0001_0000, 1'b1);
        send_coeff(1'b1, 32'h0001_0000, 1'b1);
        // first-operand item between second-operand items
        send_coeff(1'b0, 32'h0000_0004, 1'b1);
        send_coeff(1'b1, 32'h0000_0001, 1'b0);
        send_coeff(1'b0, 32'h0000_0005, 1'b0);
        send_coeff(1'b1, 32'hffff_ffff, 1'b1);
        wait_drained();

        random_start = items_sent;
        seq          = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (seq)
                0:
                begin
                    na = $urandom_range(33, 35);
                    nb = $urandom_range(1, 3);
                end
                1:
                begin
                    na = $urandom_range(1, 3);
                    nb = $urandom_range(33, 35);
                end
                2:
                begin
                    na = TERMS;
                    nb = TERMS;
                end
                default:
                begin
                    na = pick_len();
                    nb = pick_len();
                    if (nb == 0)
                        nb = 1;
                end
            endcase
            gaps_on = ($urandom_range(0, 9) >= 3);
            send_product(na, nb);
            // sender holds back until every product so far has come out
            if (seq == 8)
                wait_drained();
            seq++;
        end
        wait_drained();

        $display("%0d coefficient items in %0d products (%0d zero, %0d with dropped terms)",
                 items_sent, sb.products, sb.zero_products, sb.dropped_products);
        $display("%0d product coefficients checked, %0d mismatches",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_terms.size() == 0)
            $display("polynomial_multiply_top regression: pass");
        else
            $display("polynomial_multiply_top regression: fail");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("polynomial_multiply_top regression: fail");
        $finish;
    end

endmodule
